// ===== src/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared types, frame constants and crc helper for the command frame builder.
// ----------------------------------------------------------------------------
package mcfb_pkg;

    localparam int FRAME_LEN = 9;
    localparam int POS_W     = 4;

    localparam logic [7:0]  HDR_BYTE  = 8'hFF;
    localparam logic [7:0]  LEN_BYTE  = 8'h07;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [7:0] FLAG_FWD   = 8'd81;
    localparam logic [7:0] FLAG_BWD   = 8'd1;
    localparam logic [7:0] FLAG_RIGHT = 8'd65;
    localparam logic [7:0] FLAG_LEFT  = 8'd17;

    typedef enum logic [2:0] {
        KIND_FWD   = 3'd0,
        KIND_BWD   = 3'd1,
        KIND_RIGHT = 3'd2,
        KIND_LEFT  = 3'd3,
        KIND_STOP  = 3'd4
    } t_kind;

    typedef enum logic [POS_W-1:0] {
        POS_HDR    = 4'd0,
        POS_LEN    = 4'd1,
        POS_LEFT_L = 4'd2,
        POS_LEFT_H = 4'd3,
        POS_RGHT_L = 4'd4,
        POS_RGHT_H = 4'd5,
        POS_FLAG   = 4'd6,
        POS_CRC_L  = 4'd7,
        POS_CRC_H  = 4'd8
    } t_pos;

    typedef struct packed {
        logic             valid;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_byte;

    function automatic logic [7:0] flag_of_kind(input logic [2:0] kind);
        logic [7:0] flag;
        case (kind)
            KIND_FWD:   flag = FLAG_FWD;
            KIND_BWD:   flag = FLAG_BWD;
            KIND_RIGHT: flag = FLAG_RIGHT;
            KIND_LEFT:  flag = FLAG_LEFT;
            default:    flag = 8'd0;
        endcase
        return flag;
    endfunction

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'd0, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/motor_command_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_builder_unit
// Turns one drive command into a nine-byte serial frame with crc-16/modbus.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its frame leaves one
// byte per cycle on consecutive cycles, each marked by o_strobe. The header
// passes the sequencer register and then the output register, and o_last marks
// the ninth byte. The byte sequencer emits one byte per clock and folds the
// length, speed and flag bytes into the crc as they pass. One output register
// follows the sequencer. busy drops while the eighth byte is on the outputs,
// which lets the next frame follow with no gap. The receiver cannot stall:
// every strobed byte must be taken in that cycle. Stop requests and unused kind
// codes give the header and length bytes followed by seven zero bytes.
module motor_command_frame_builder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_kind,
    input  logic signed [15:0]          i_left_speed,
    input  logic signed [15:0]          i_right_speed,
    output logic                        o_strobe,
    output logic [7:0]                  o_frame_byte,
    output logic [mcfb_pkg::POS_W-1:0]  o_byte_position,
    output logic                        o_last
);

    logic                         load;
    mcfb_pkg::t_byte              gen_byte;
    logic                         r_strobe;
    logic [7:0]                   r_data;
    logic [mcfb_pkg::POS_W-1:0]   r_position;
    logic                         r_last;

    assign load = start && !busy;

    mcfb_frame_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_kind        (i_kind),
        .i_left_speed  (i_left_speed),
        .i_right_speed (i_right_speed),
        .o_busy        (busy),
        .o_byte        (gen_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= gen_byte.valid;
        end
        r_data     <= gen_byte.data;
        r_position <= gen_byte.pos;
        r_last     <= gen_byte.last;
    end

    assign o_strobe        = r_strobe;
    assign o_frame_byte    = r_data;
    assign o_byte_position = r_position;
    assign o_last          = r_strobe && r_last;

endmodule

// ===== src/mcfb_frame_gen.sv =====
// ----------------------------------------------------------------------------
// mcfb_frame_gen
// Command register, byte position counter, running crc and byte select.
// ----------------------------------------------------------------------------
module mcfb_frame_gen (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [2:0]                i_kind,
    input  logic [15:0]               i_left_speed,
    input  logic [15:0]               i_right_speed,
    output logic                      o_busy,
    output mcfb_pkg::t_byte           o_byte
);

    logic                         r_active, n_active;
    logic [mcfb_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [2:0]                   r_kind, n_kind;
    logic [15:0]                  r_left, n_left;
    logic [15:0]                  r_right, n_right;
    logic [15:0]                  r_crc, n_crc;
    logic [7:0]                   cur_byte;
    logic                         motion;
    logic                         is_last;

    assign motion  = (r_kind < mcfb_pkg::KIND_STOP);
    assign is_last = (r_pos == mcfb_pkg::POS_CRC_H);

    always_comb begin
        cur_byte = 8'd0;
        case (r_pos)
            mcfb_pkg::POS_HDR:    cur_byte = mcfb_pkg::HDR_BYTE;
            mcfb_pkg::POS_LEN:    cur_byte = mcfb_pkg::LEN_BYTE;
            mcfb_pkg::POS_LEFT_L: cur_byte = motion ? r_left[7:0]   : 8'd0;
            mcfb_pkg::POS_LEFT_H: cur_byte = motion ? r_left[15:8]  : 8'd0;
            mcfb_pkg::POS_RGHT_L: cur_byte = motion ? r_right[7:0]  : 8'd0;
            mcfb_pkg::POS_RGHT_H: cur_byte = motion ? r_right[15:8] : 8'd0;
            mcfb_pkg::POS_FLAG:   cur_byte = motion ? mcfb_pkg::flag_of_kind(r_kind) : 8'd0;
            mcfb_pkg::POS_CRC_L:  cur_byte = motion ? r_crc[7:0]    : 8'd0;
            mcfb_pkg::POS_CRC_H:  cur_byte = motion ? r_crc[15:8]   : 8'd0;
            default:              cur_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_left   = r_left;
        n_right  = r_right;
        n_crc    = r_crc;
        if (i_load) begin
            n_active = 1'b1;
            n_pos    = mcfb_pkg::POS_HDR;
            n_kind   = i_kind;
            n_left   = i_left_speed;
            n_right  = i_right_speed;
            n_crc    = mcfb_pkg::CRC_INIT;
        end else if (r_active) begin
            if (is_last) begin
                n_active = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
            if (r_pos >= mcfb_pkg::POS_LEN && r_pos <= mcfb_pkg::POS_FLAG) begin
                n_crc = mcfb_pkg::crc16_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= mcfb_pkg::POS_HDR;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
        end
        r_kind  <= n_kind;
        r_left  <= n_left;
        r_right <= n_right;
        r_crc   <= n_crc;
    end

    assign o_busy       = r_active && !is_last;
    assign o_byte.valid = r_active;
    assign o_byte.data  = cur_byte;
    assign o_byte.pos   = r_pos;
    assign o_byte.last  = is_last;

endmodule

// ===== src/mcfb_checker.sv =====
// ----------------------------------------------------------------------------
// mcfb_checker
// Port-level checks on frame ordering and request timing.
// ----------------------------------------------------------------------------
module mcfb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [7:0]                  o_frame_byte,
    input logic [mcfb_pkg::POS_W-1:0]  o_byte_position,
    input logic                        o_last
);

    // bytes of one frame come back to back
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe &&
            o_byte_position == $past(o_byte_position) + 1'b1)
        else $error("frame byte sequence broken");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> o_byte_position == mcfb_pkg::POS_CRC_H)
        else $error("last flag on wrong byte");

    // request shows up as header behind the sequencer and output registers
    a_req_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe && o_byte_position == mcfb_pkg::POS_HDR &&
            o_frame_byte == mcfb_pkg::HDR_BYTE)
        else $error("request did not start a frame");

    // no new request while the frame is far from done
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_byte_position < mcfb_pkg::POS_CRC_L |-> busy)
        else $error("busy dropped mid frame");

endmodule

bind motor_command_frame_builder_unit mcfb_checker u_mcfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_frame_byte    (o_frame_byte),
    .o_byte_position (o_byte_position),
    .o_last          (o_last)
);
